// ----- design/abtpq_pkg.sv -----
package abtpq_pkg;

  // table depth, one chain cell per stored box
  localparam int unsigned MAX_BOXES = 64;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the configuration port (paddr[2])
  localparam logic REG_CURRENT_FLOOR = 1'b0;

  localparam logic [1:0] FLOOR_INVALID = 2'd3;

  typedef enum logic [1:0] {
    MODE_SAVE  = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_FLOOR = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [1:0]         floor;
    logic [15:0]        box_id;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] bottom;
    logic signed [31:0] top;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } cmd_t;

  typedef struct packed {
    logic    hit;
    status_t status;
  } res_t;

  // item travelling down the cell chain
  typedef struct packed {
    logic valid;
    logic claimed;
    logic hit;
    cmd_t cmd;
  } tok_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

// ----- design/aabb_box_table_point_query.sv -----
// an accepted item walks the cell chain to the tail, whose hand-off loads the result register
// no new item is taken while one is in flight; the item walks the cell chain
// one cell per cycle; the next item enters once the previous one has left the chain
// reset (rst, synchronous, active high) empties the table and sets current_floor to 0
// a stalled result holds the chain; boxes need no clearing pass after reset
module aabb_box_table_point_query (
  input  logic                                clk,
  input  logic                                rst,
  // item input
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  abtpq_pkg::cmd_t                     cmd,
  // result output
  output logic                                res_valid,
  input  logic                                res_stall,
  output abtpq_pkg::res_t                     res,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [abtpq_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [abtpq_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [abtpq_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  // configuration register
  logic [1:0] current_floor;

  // one item in flight at a time; busy covers entry to tail hand-off
  logic busy;
  logic cmd_acc;

  // chain of tokens: tok[0] feeds cell 0, tok[MAX_BOXES] is the tail
  abtpq_pkg::tok_t tok [abtpq_pkg::MAX_BOXES+1];
  logic [abtpq_pkg::MAX_BOXES-1:0] tok_live;

  logic tail_valid;
  logic adv;
  logic res_load;
  abtpq_pkg::res_t res_next;

  // apb: always ready, word address bit 2 picks the register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_floor <= 2'd0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == abtpq_pkg::REG_CURRENT_FLOOR)) begin
      current_floor <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == abtpq_pkg::REG_CURRENT_FLOOR) begin
      prdata = {{(abtpq_pkg::CFG_DATA_W-2){1'b0}}, current_floor};
    end
  end

  // input side: take an item only when the chain is empty
  assign cmd_stall = busy;
  assign cmd_acc   = cmd_valid && !busy;

  always_comb begin
    tok[0].valid   = cmd_acc;
    tok[0].claimed = 1'b0;
    tok[0].hit     = 1'b0;
    tok[0].cmd     = cmd;
  end

  // the chain freezes only while the tail item waits on a full result register
  assign tail_valid = tok[abtpq_pkg::MAX_BOXES].valid;
  assign adv        = !(tail_valid && res_valid && res_stall);
  assign res_load   = tail_valid && adv;

  for (genvar i = 0; i < abtpq_pkg::MAX_BOXES; i++) begin : g_cell
    abtpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cur_floor (current_floor),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
    assign tok_live[i] = tok[i+1].valid;
  end

  // result from the tail token
  always_comb begin
    res_next.hit    = 1'b0;
    res_next.status = abtpq_pkg::STATUS_DONE;
    case (tok[abtpq_pkg::MAX_BOXES].cmd.mode)
      abtpq_pkg::MODE_SAVE: begin
        if (tok[abtpq_pkg::MAX_BOXES].cmd.floor == abtpq_pkg::FLOOR_INVALID) begin
          res_next.status = abtpq_pkg::STATUS_BAD_FLOOR;
        end else if (!tok[abtpq_pkg::MAX_BOXES].claimed) begin
          // no free cell anywhere down the chain
          res_next.status = abtpq_pkg::STATUS_FULL;
        end
      end
      abtpq_pkg::MODE_QUERY: begin
        res_next.hit = tok[abtpq_pkg::MAX_BOXES].hit;
      end
      default: begin
        res_next.hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_acc) begin
        busy <= 1'b1;
      end else if (res_load) begin
        busy <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_live))
    else $error("more than one item in the cell chain");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    (|tok_live) |-> busy)
    else $error("item in chain while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> busy && tok[1].valid)
    else $error("accepted item did not enter the chain");

  a_res_from_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(tail_valid))
    else $error("result appeared without a tail item");
`endif

endmodule

// ----- design/abtpq_cell.sv -----
module abtpq_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [1:0]        cur_floor,
  input  abtpq_pkg::tok_t   tok_in,
  output abtpq_pkg::tok_t   tok_out
);

  logic               used;
  logic [1:0]         floor;
  logic [15:0]        box_id;
  logic signed [31:0] org_cx, org_cy;
  logic signed [31:0] org_l, org_r, org_b, org_t;
  logic signed [31:0] cur_l, cur_r, cur_b, cur_t;

  // move in two steps: translated center first, bounds in the following cycle
  logic               pend;
  logic signed [31:0] mv_cx, mv_cy;

  logic on_floor;
  logic take_save;
  logic do_move;
  logic in_box;

  assign on_floor  = used && (floor == cur_floor);
  assign take_save = tok_in.valid && (tok_in.cmd.mode == abtpq_pkg::MODE_SAVE) &&
                     (tok_in.cmd.floor != abtpq_pkg::FLOOR_INVALID) &&
                     !tok_in.claimed && !used;
  assign do_move   = tok_in.valid && (tok_in.cmd.mode == abtpq_pkg::MODE_MOVE) &&
                     on_floor && (box_id == tok_in.cmd.box_id);
  assign in_box    = on_floor &&
                     (tok_in.cmd.pos_y >= cur_b) && (tok_in.cmd.pos_y <= cur_t) &&
                     (tok_in.cmd.pos_x >= cur_l) && (tok_in.cmd.pos_x <= cur_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      pend          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      if (pend) begin
        cur_l <= abtpq_pkg::sat_add(mv_cx, org_l);
        cur_r <= abtpq_pkg::sat_add(mv_cx, org_r);
        cur_b <= abtpq_pkg::sat_add(mv_cy, org_b);
        cur_t <= abtpq_pkg::sat_add(mv_cy, org_t);
        pend  <= 1'b0;
      end
      if (adv) begin
        tok_out.valid   <= tok_in.valid;
        tok_out.claimed <= tok_in.claimed | take_save;
        tok_out.hit     <= tok_in.hit |
                           (tok_in.valid && (tok_in.cmd.mode == abtpq_pkg::MODE_QUERY) &&
                            in_box);
        tok_out.cmd     <= tok_in.cmd;
        if (take_save) begin
          used   <= 1'b1;
          floor  <= tok_in.cmd.floor;
          box_id <= tok_in.cmd.box_id;
          org_cx <= tok_in.cmd.center_x;
          org_cy <= tok_in.cmd.center_y;
          org_l  <= tok_in.cmd.left;
          org_r  <= tok_in.cmd.right;
          org_b  <= tok_in.cmd.bottom;
          org_t  <= tok_in.cmd.top;
          cur_l  <= tok_in.cmd.left;
          cur_r  <= tok_in.cmd.right;
          cur_b  <= tok_in.cmd.bottom;
          cur_t  <= tok_in.cmd.top;
        end
        if (do_move) begin
          pend  <= 1'b1;
          mv_cx <= abtpq_pkg::sat_add(org_cx, tok_in.cmd.pos_x);
          mv_cy <= abtpq_pkg::sat_add(org_cy, tok_in.cmd.pos_y);
        end
      end
    end
  end

endmodule
